// ===== design/cst_pkg.sv =====
// shared types, character codes and helper functions for the character stream tokenizer
package cst_pkg;

  localparam int POS_BITS = 16;
  localparam int RES_W    = 16;
  localparam int WIDE_W   = POS_BITS + RES_W;

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
  localparam logic [RES_W-1:0]    LEN_MAX = {RES_W{1'b1}};
  localparam logic [RES_W-1:0]    LEN_ONE = RES_W'(1);

  typedef logic [POS_BITS-1:0] pos_t;

  typedef enum logic [4:0] {
    K_WORD    = 5'd0,
    K_STRING  = 5'd1,
    K_NUMBER  = 5'd2,
    K_LPAREN  = 5'd3,
    K_RPAREN  = 5'd4,
    K_LBRACK  = 5'd5,
    K_RBRACK  = 5'd6,
    K_LBRACE  = 5'd7,
    K_RBRACE  = 5'd8,
    K_LT      = 5'd9,
    K_GT      = 5'd10,
    K_COMMA   = 5'd11,
    K_SEMI    = 5'd12,
    K_STAR    = 5'd13,
    K_PLUS    = 5'd14,
    K_MINUS   = 5'd15,
    K_SLASH   = 5'd16,
    K_PERCENT = 5'd17,
    K_EQUAL   = 5'd18,
    K_EOF     = 5'd19
  } kind_t;

  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;

  typedef struct packed {
    kind_t            kind;
    logic [RES_W-1:0] start;
    logic [RES_W-1:0] len;
    logic             last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } step_out_t;

  typedef struct packed {
    logic       hit;
    kind_t      kind;
  } punct_t;

  function automatic punct_t punct_of(input logic [7:0] c);
    punct_t p;
    p.hit  = 1'b1;
    p.kind = K_WORD;
    case (c)
      8'h28:   p.kind = K_LPAREN;
      8'h29:   p.kind = K_RPAREN;
      8'h5B:   p.kind = K_LBRACK;
      8'h5D:   p.kind = K_RBRACK;
      8'h7B:   p.kind = K_LBRACE;
      8'h7D:   p.kind = K_RBRACE;
      8'h3C:   p.kind = K_LT;
      8'h3E:   p.kind = K_GT;
      8'h2C:   p.kind = K_COMMA;
      8'h3B:   p.kind = K_SEMI;
      8'h2A:   p.kind = K_STAR;
      8'h2B:   p.kind = K_PLUS;
      8'h2D:   p.kind = K_MINUS;
      8'h2F:   p.kind = K_SLASH;
      8'h25:   p.kind = K_PERCENT;
      8'h3D:   p.kind = K_EQUAL;
      default: p.hit  = 1'b0;
    endcase
    return p;
  endfunction

  function automatic logic [RES_W-1:0] start_of(input pos_t p);
    return RES_W'(p);
  endfunction

  function automatic logic [RES_W-1:0] len_of(input pos_t s, input pos_t e);
    pos_t              d;
    logic [WIDE_W-1:0] dw;
    d  = (e > s) ? e - s : '0;
    dw = WIDE_W'(d);
    return (dw > WIDE_W'(LEN_MAX)) ? LEN_MAX : RES_W'(d);
  endfunction

  function automatic res_t mk_res(input kind_t k, input pos_t s, input logic [RES_W-1:0] l);
    res_t r;
    r.kind  = k;
    r.start = start_of(s);
    r.len   = l;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

// ===== design/char_stream_tokenizer.sv =====
// top level of the character stream tokenizer
// One source byte is taken per beat and every beat yields up to two tokens
// (kind, start position, length, last). A byte is held in the input
// register, is decided by the tokenizer state logic and lands in a two-slot
// result buffer, from which its tokens are sent out. A new byte is taken
// every cycle while each byte yields at most one token and the output is not
// stalled; a byte that yields two tokens (a word or number closed by a
// punctuation mark, or a pending token flushed at end of input) holds the
// input while the result buffer drains. The input beat with end_of_input set
// closes any number or word, gives an EOF token and returns the position to
// zero for the next source.
module char_stream_tokenizer import cst_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_kind,
  output logic [15:0] out_start_res,
  output logic [15:0] out_length,
  output logic        out_last
);

  logic       s1_v_r;
  logic [7:0] s1_ch_r;
  logic       s1_eoi_r;
  logic       ready;
  logic       adv;
  step_out_t  so;

  assign adv      = s1_v_r && ready;
  assign in_stall = s1_v_r && !ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (!in_stall) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_ch_r  <= in_ch;
      s1_eoi_r <= in_end_of_input;
    end
  end

  cst_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .ch    (s1_ch_r),
    .eoi   (s1_eoi_r),
    .so    (so)
  );

  cst_outbuf u_outbuf (
    .clk           (clk),
    .rst_n         (rst_n),
    .wr            (adv),
    .si            (so),
    .ready         (ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_start_res (out_start_res),
    .out_length    (out_length),
    .out_last      (out_last)
  );

endmodule

// ===== design/cst_core.sv =====
// tokenizer state and per-character token decision
module cst_core import cst_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic [7:0] ch,
  input  logic       eoi,
  output step_out_t  so
);

  pos_t pos_r, pos_nxt;
  pos_t bs_r, bs_nxt;
  logic nb_r, nb_nxt;
  logic sm_r, sm_nxt;
  logic qs_r, qs_nxt;
  logic nm_r, nm_nxt;

  pos_t       p, nxt_p, bs_w;
  logic       nb_w;
  logic       is_dig, is_blank, is_quote, ends_word, done;
  punct_t     pc;
  res_t       rr [2];
  logic [1:0] cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      bs_r  <= '0;
      nb_r  <= 1'b0;
      sm_r  <= 1'b0;
      qs_r  <= 1'b0;
      nm_r  <= 1'b0;
    end else if (adv) begin
      pos_r <= pos_nxt;
      bs_r  <= bs_nxt;
      nb_r  <= nb_nxt;
      sm_r  <= sm_nxt;
      qs_r  <= qs_nxt;
      nm_r  <= nm_nxt;
    end
  end

  always_comb begin
    p         = pos_r;
    nxt_p     = (pos_r == POS_MAX) ? pos_r : pos_r + POS_BITS'(1);
    is_dig    = (ch >= CH_0) && (ch <= CH_9);
    is_blank  = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_NL) ||
                (ch == CH_CR) || (ch == CH_VT) || (ch == CH_FF);
    is_quote  = (ch == CH_DQUOTE) || (ch == CH_SQUOTE);
    pc        = punct_of(ch);
    ends_word = (ch == CH_SPACE) || (ch == CH_NL) || pc.hit;
    rr[0]     = '0;
    rr[1]     = '0;
    cnt       = 2'd0;
    done      = 1'b0;
    bs_w      = bs_r;
    nb_w      = nb_r;

    pos_nxt = nxt_p;
    bs_nxt  = bs_r;
    nb_nxt  = nb_r;
    sm_nxt  = sm_r;
    qs_nxt  = qs_r;
    nm_nxt  = nm_r;

    if (eoi) begin
      if (!sm_r && nm_r) begin
        rr[cnt[0]] = mk_res(K_NUMBER, bs_r, len_of(bs_r, p));
        cnt        = cnt + 2'd1;
      end else if (!sm_r && nb_r) begin
        rr[cnt[0]] = mk_res(K_WORD, bs_r, len_of(bs_r, p));
        cnt        = cnt + 2'd1;
      end
      rr[cnt[0]] = mk_res(K_EOF, p, '0);
      cnt        = cnt + 2'd1;
      pos_nxt    = '0;
      bs_nxt     = '0;
      nb_nxt     = 1'b0;
      sm_nxt     = 1'b0;
      qs_nxt     = 1'b0;
      nm_nxt     = 1'b0;
    end else if (sm_r) begin
      if (ch == (qs_r ? CH_SQUOTE : CH_DQUOTE)) begin
        rr[cnt[0]] = mk_res(K_STRING, bs_r, len_of(bs_r, p));
        cnt        = cnt + 2'd1;
        bs_nxt     = nxt_p;
        nb_nxt     = 1'b0;
        sm_nxt     = 1'b0;
      end
    end else begin
      if (nm_r) begin
        if (is_dig || (ch == CH_DOT)) begin
          done = 1'b1;
        end else begin
          rr[cnt[0]] = mk_res(K_NUMBER, bs_r, len_of(bs_r, p));
          cnt        = cnt + 2'd1;
          bs_w       = p;
          nb_w       = 1'b0;
          nm_nxt     = 1'b0;
          bs_nxt     = p;
          nb_nxt     = 1'b0;
        end
      end
      if (!done) begin
        if (is_quote) begin
          sm_nxt = 1'b1;
          qs_nxt = (ch == CH_SQUOTE);
          bs_nxt = nxt_p;
          nb_nxt = 1'b0;
        end else if (ends_word) begin
          if (nb_w) begin
            rr[cnt[0]] = mk_res(K_WORD, bs_w, len_of(bs_w, p));
            cnt        = cnt + 2'd1;
          end
          if (pc.hit) begin
            rr[cnt[0]] = mk_res(pc.kind, p, LEN_ONE);
            cnt        = cnt + 2'd1;
          end
          bs_nxt = nxt_p;
          nb_nxt = 1'b0;
        end else begin
          if (is_dig) begin
            nm_nxt = 1'b1;
          end
          if (!is_blank) begin
            nb_nxt = 1'b1;
          end
        end
      end
    end

    if (cnt == 2'd1) begin
      rr[0].last = 1'b1;
    end
    if (cnt == 2'd2) begin
      rr[1].last = 1'b1;
    end
    so.n  = cnt;
    so.r0 = rr[0];
    so.r1 = rr[1];
  end

  // a string and a number are never open together
  a_modes_excl: assert property (@(posedge clk) disable iff (!rst_n) !(sm_r && nm_r))
    else $error("string and number mode both set");

  // end of input returns the scanner to its reset state
  a_eoi_clear: assert property (@(posedge clk) disable iff (!rst_n)
    adv && eoi |=> pos_r == '0 && !sm_r && !nm_r && !nb_r)
    else $error("state not cleared after end of input");

  // end of input always ends with an eof token
  a_eoi_eof: assert property (@(posedge clk) disable iff (!rst_n)
    eoi |-> ((so.n == 2'd1 && so.r0.kind == K_EOF) || (so.n == 2'd2 && so.r1.kind == K_EOF)))
    else $error("end of input without eof token");

endmodule

// ===== design/cst_outbuf.sv =====
// two-slot result buffer holding up to two tokens per character
module cst_outbuf import cst_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  step_out_t        si,
  output logic             ready,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [4:0]       out_kind,
  output logic [RES_W-1:0] out_start_res,
  output logic [RES_W-1:0] out_length,
  output logic             out_last
);

  res_t a_r, a_nxt;
  res_t b_r, b_nxt;
  logic a_v_r, a_v_nxt;
  logic b_v_r, b_v_nxt;
  logic take;

  assign take  = a_v_r && !out_stall;
  assign ready = !a_v_r || (take && !b_v_r);

  always_comb begin
    a_nxt   = a_r;
    b_nxt   = b_r;
    a_v_nxt = a_v_r;
    b_v_nxt = b_v_r;
    if (take) begin
      a_nxt   = b_r;
      a_v_nxt = b_v_r;
      b_v_nxt = 1'b0;
    end
    if (wr) begin
      a_nxt   = si.r0;
      b_nxt   = si.r1;
      a_v_nxt = (si.n != 2'd0);
      b_v_nxt = (si.n == 2'd2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      a_v_r <= a_v_nxt;
      b_v_r <= b_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  assign out_valid     = a_v_r;
  assign out_kind      = a_r.kind;
  assign out_start_res = a_r.start;
  assign out_length    = a_r.len;
  assign out_last      = a_r.last;

  // second slot only fills behind the first
  a_order: assert property (@(posedge clk) disable iff (!rst_n) b_v_r |-> a_v_r)
    else $error("second slot valid with first empty");

  // writes only land in an empty buffer or one whose single token is being taken
  a_wr_room: assert property (@(posedge clk) disable iff (!rst_n) wr |-> ready)
    else $error("write into full result buffer");

  // a pair of tokens fills both slots
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    wr && si.n == 2'd2 |=> a_v_r && b_v_r && !a_r.last && b_r.last)
    else $error("token pair not held in both slots");

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for the character stream tokenizer with random idling on both sides
`timescale 1ns / 100ps

module testbench;
  import cst_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_BYTES = 700;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } src_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_ch = 8'h00;
  logic        in_end_of_input = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  out_kind;
  logic [15:0] out_start_res;
  logic [15:0] out_length;
  logic        out_last;

  src_beat_t src_q[$];
  res_t      token_q[$];

  // tokenizer state as predicted
  pos_t cur_pos = '0;
  pos_t text_start = '0;
  bit   text_nonblank = 1'b0;
  bit   in_quote = 1'b0;
  bit   quote_sq = 1'b0;
  bit   num_open = 1'b0;

  string punct_marks = "()[]{}<>,;*+-/%=";
  bit    idle_on = 1'b0;
  int    send_gap = 0;
  int    send_calm = 0;
  int    hold_left = 0;
  int    recv_calm = 0;
  int    pushed = 0;
  int    beats_in = 0;
  int    eof_seen = 0;
  int    tokens_seen = 0;
  int    errors = 0;
  int    cycles = 0;

  char_stream_tokenizer u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_ch           (in_ch),
    .in_end_of_input (in_end_of_input),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_start_res   (out_start_res),
    .out_length      (out_length),
    .out_last        (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap(inout int calm);
    int r;
    if (!idle_on) return 0;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 999);
    if (r < 5) begin
      calm = $urandom_range(40, 200);
      return 0;
    end
    if (r < 700) return 0;
    if (r < 960) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int punct_slot(input logic [7:0] c);
    for (int i = 0; i < punct_marks.len(); i++) begin
      if (punct_marks[i] == c) return i;
    end
    return -1;
  endfunction

  function automatic bit is_digit_byte(input logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic bit is_blank_byte(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_CR || c == CH_VT ||
           c == CH_FF;
  endfunction

  function automatic res_t token_of(input kind_t k, input pos_t s, input logic [POS_BITS:0] e);
    res_t              r;
    logic [POS_BITS:0] d;
    d = (e > {1'b0, s}) ? e - {1'b0, s} : '0;
    r.kind  = k;
    r.start = RES_W'(s);
    r.len   = (d > (POS_BITS + 1)'(LEN_MAX)) ? LEN_MAX : RES_W'(d);
    r.last  = 1'b0;
    return r;
  endfunction

  task automatic tokenize_byte(input logic [7:0] c, input logic eoi);
    res_t              fresh[$];
    res_t              r;
    pos_t              p;
    pos_t              nxt;
    logic [POS_BITS:0] pw;
    int                pk;
    p   = cur_pos;
    pw  = {1'b0, p};
    nxt = (p == POS_MAX) ? p : p + 1'b1;
    pk  = punct_slot(c);
    if (eoi) begin
      if (!in_quote) begin
        if (num_open) fresh.insert(fresh.size(), token_of(K_NUMBER, text_start, pw));
        else if (text_nonblank) fresh.insert(fresh.size(), token_of(K_WORD, text_start, pw));
      end
      fresh.insert(fresh.size(), token_of(K_EOF, p, pw));
      cur_pos       = '0;
      text_start    = '0;
      text_nonblank = 1'b0;
      in_quote      = 1'b0;
      quote_sq      = 1'b0;
      num_open      = 1'b0;
    end else begin
      if (in_quote) begin
        if (c == (quote_sq ? CH_SQUOTE : CH_DQUOTE)) begin
          fresh.insert(fresh.size(), token_of(K_STRING, text_start, pw));
          text_start    = nxt;
          text_nonblank = 1'b0;
          in_quote      = 1'b0;
        end
      end else if (!num_open || !(is_digit_byte(c) || c == CH_DOT)) begin
        // a number closed by another byte, which is then taken afresh
        if (num_open) begin
          fresh.insert(fresh.size(), token_of(K_NUMBER, text_start, pw));
          text_start    = p;
          text_nonblank = 1'b0;
          num_open      = 1'b0;
        end
        if (c == CH_DQUOTE || c == CH_SQUOTE) begin
          in_quote      = 1'b1;
          quote_sq      = (c == CH_SQUOTE);
          text_start    = nxt;
          text_nonblank = 1'b0;
        end else if (c == CH_SPACE || c == CH_NL || pk >= 0) begin
          if (text_nonblank) fresh.insert(fresh.size(), token_of(K_WORD, text_start, pw));
          if (pk >= 0)
            fresh.insert(fresh.size(),
                         token_of(kind_t'(int'(K_LPAREN) + pk), p, pw + 1'b1));
          text_start    = nxt;
          text_nonblank = 1'b0;
        end else begin
          if (is_digit_byte(c)) num_open = 1'b1;
          if (!is_blank_byte(c)) text_nonblank = 1'b1;
        end
      end
      cur_pos = nxt;
    end
    for (int i = 0; i < fresh.size(); i++) begin
      r = fresh[i];
      r.last = (i == fresh.size() - 1);
      token_q.insert(token_q.size(), r);
    end
  endtask

  task automatic push_byte(input logic [7:0] c);
    src_q.insert(src_q.size(), '{ch: c, eoi: 1'b0});
    pushed++;
  endtask

  task automatic push_eof();
    src_q.insert(src_q.size(), '{ch: 8'($urandom_range(0, 255)), eoi: 1'b1});
    pushed++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // one lexical piece: word, number, quoted string, mark, blank, stray byte or end of source
  task automatic add_fragment(input bit allow_eof);
    int         pick;
    int         n;
    logic [7:0] q;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      n = $urandom_range(1, 6);
      repeat (n) push_byte(8'($urandom_range(97, 122)));
    end else if (pick < 40) begin
      push_byte(CH_0 + 8'($urandom_range(0, 9)));
      n = $urandom_range(0, 4);
      repeat (n)
        push_byte(($urandom_range(0, 3) == 0) ? CH_DOT : CH_0 + 8'($urandom_range(0, 9)));
    end else if (pick < 52) begin
      q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
      push_byte(q);
      n = $urandom_range(0, 5);
      repeat (n) begin
        b = 8'($urandom_range(0, 255));
        if (b == q) b = CH_SPACE;
        push_byte(b);
      end
      if ($urandom_range(0, 9) != 0) push_byte(q);
    end else if (pick < 67) begin
      push_byte(punct_marks[$urandom_range(0, 15)]);
    end else if (pick < 80) begin
      case ($urandom_range(0, 5))
        0: push_byte(CH_SPACE);
        1: push_byte(CH_NL);
        2: push_byte(CH_TAB);
        3: push_byte(CH_CR);
        4: push_byte(CH_VT);
        default: push_byte(CH_FF);
      endcase
    end else if (pick < 93 || !allow_eof) begin
      push_byte(8'($urandom_range(0, 255)));
    end else begin
      push_eof();
    end
  endtask

  task automatic log_error(input string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic wait_drained();
    while (src_q.size() != 0 || in_valid || token_q.size() != 0) @(posedge clk);
  endtask

  // source side
  always @(posedge clk) begin
    src_beat_t b;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        tokenize_byte(in_ch, in_end_of_input);
        beats_in++;
        if (in_end_of_input) eof_seen++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap == 0 && src_q.size() != 0) begin
          b = src_q.pop_front();
          in_valid        <= 1'b1;
          in_ch           <= b.ch;
          in_end_of_input <= b.eoi;
          send_gap = pick_gap(send_calm);
        end else begin
          in_valid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end
      end
    end
  end

  // token side
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        tokens_seen++;
        if (token_q.size() == 0) begin
          log_error($sformatf("unexpected token kind %0d start %0d len %0d last %0b",
                              out_kind, out_start_res, out_length, out_last));
        end else begin
          want = token_q.pop_front();
          if (out_kind !== want.kind || out_start_res !== want.start ||
              out_length !== want.len || out_last !== want.last)
            log_error($sformatf({"token %0d want kind %0d start %0d len %0d last %0b,",
                                 " got %0d %0d %0d %0b"},
                                tokens_seen, want.kind, want.start, want.len, want.last,
                                out_kind, out_start_res, out_length, out_last));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        hold_left = pick_gap(recv_calm);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int mark;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    idle_on = 1'b1;
    push_text("ab(3.5)[]{}<>,;*+-/%=");
    push_text("w'q\"'");
    push_text("\t7");
    push_eof();
    push_text("k");
    push_eof();
    push_byte(8'h00);
    push_byte(8'hFF);
    push_text("\"a");
    push_eof();
    wait_drained();

    mark = pushed;
    while (pushed - mark < RANDOM_BYTES) add_fragment(1'b1);
    push_text("z9");
    push_eof();
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (token_q.size() != 0) log_error($sformatf("%0d tokens never arrived", token_q.size()));
    $display("%0d source beats in %0d sources, %0d tokens checked, %0d mismatches",
             beats_in, eof_seen, tokens_seen, errors);
    $display("covered every mark, quoted and unterminated strings, numbers and words");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/cst_pkg.sv
design/cst_core.sv
design/cst_outbuf.sv
design/char_stream_tokenizer.sv
test/testbench.sv
